// ===== sv/ipv4_prefix_match_table_assert.svh =====
// Assertion macros for the IPv4 prefix match table.
`ifndef IPV4_PREFIX_MATCH_TABLE_ASSERT_SVH
`define IPV4_PREFIX_MATCH_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define IPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipm assertion failed");

// Next-cycle implication, checked out of reset.
`define IPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipm assertion failed");

`endif

// ===== sv/ipm_pkg.sv =====
// Shared types, constants and helpers for the IPv4 prefix match table.
package ipm_pkg;

    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 6;
    localparam int KEY_W             = 7;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 2;
    localparam int MAX_LEN           = 32;
    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  prefix_length;
        logic [KEY_W-1:0]  route_key;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic [KEY_W-1:0]    match_key;
        logic [STATUS_W-1:0] status;
    } rsp_t;

    typedef struct packed {
        logic ins;
        logic del;
        logic lkp;
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  key;
    } q_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [KEY_W-1:0]  tag;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

// ===== sv/ipm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ipm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/ipm_front.sv =====
// Request front end: length saturation, prefix masking and operation decode.
module ipm_front (
    input  logic           req_valid,
    output logic           req_stall,
    input  ipm_pkg::req_t  req,
    input  logic           q_full,
    output logic           push,
    output ipm_pkg::q_item_t item
);
    import ipm_pkg::*;

    logic [LEN_W-1:0] len_sat;

    always_comb
    begin
        len_sat = (req.prefix_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : req.prefix_length;
        item      = '0;
        item.addr = req.address;
        item.len  = len_sat;
        item.base = req.address & prefix_mask(len_sat);
        item.key  = req.route_key;
        unique case (req.operation)
            OP_INSERT: item.kind.ins = 1'b1;
            OP_DELETE: item.kind.del = 1'b1;
            OP_LOOKUP: item.kind.lkp = 1'b1;
            default:   item.kind     = '0;
        endcase
    end

    assign req_stall = q_full;
    assign push      = req_valid & ~q_full;

endmodule

// ===== sv/ipm_queue.sv =====
// Two-entry queue between the front end and the table engine.
module ipm_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ipm_pkg::q_item_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output ipm_pkg::q_item_t  head
);
    import ipm_pkg::*;

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/ipm_engine.sv =====
// Table engine: scans every entry per known op, then updates the table and issues the result.
module ipm_engine #(
    parameter int TABLE_ENTRIES = ipm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  ipm_pkg::q_item_t  head,
    output logic              pop,
    output logic              busy,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ipm_pkg::rsp_t     rsp
);
    import ipm_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAST = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    q_item_t cur_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    logic             chk_reg, chk_next;
    logic             chk_live_reg;
    logic [IDX_W-1:0] chk_idx_reg;

    logic             dup_reg, dup_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             del_found_reg, del_found_next;
    logic [IDX_W-1:0] del_idx_reg, del_idx_next;
    logic             hit_reg, hit_next;
    logic [LEN_W-1:0] best_len_reg, best_len_next;
    logic [KEY_W-1:0] best_key_reg, best_key_next;

    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;
    logic             ram_wr_en;
    entry_t           ram_wr_entry;
    entry_t           ent;
    logic             exact, covers, fin_fire;

    ipm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (ram_wr_entry),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (ram_rd_data)
    );

    assign ent    = entry_t'(ram_rd_data);
    assign exact  = chk_live_reg && (ent.base == cur_reg.base) && (ent.len == cur_reg.len);
    assign covers = chk_live_reg && ((cur_reg.addr & prefix_mask(ent.len)) == ent.base);

    assign pop       = (state_reg == S_IDLE) && head_valid;
    assign busy      = (state_reg != S_IDLE);
    assign ram_rd_en = (state_reg == S_SCAN);
    assign fin_fire  = (state_reg == S_FIN) && (!rsp_valid_reg || !rsp_stall);
    assign ram_wr_en = fin_fire && cur_reg.kind.ins && !dup_reg && free_found_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        ram_wr_entry      = '0;
        ram_wr_entry.base = cur_reg.base;
        ram_wr_entry.len  = cur_reg.len;
        ram_wr_entry.tag  = cur_reg.key;
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        chk_next        = 1'b0;
        valid_next      = valid_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        del_found_next  = del_found_reg;
        del_idx_next    = del_idx_reg;
        hit_next        = hit_reg;
        best_len_next   = best_len_reg;
        best_key_next   = best_key_reg;
        rsp_valid_next  = rsp_valid_reg & rsp_stall;
        rsp_next        = rsp_reg;

        if (chk_reg)
        begin
            if (exact)
            begin
                dup_next = 1'b1;
                if (!del_found_reg)
                begin
                    del_found_next = 1'b1;
                    del_idx_next   = chk_idx_reg;
                end
            end
            if (!chk_live_reg && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = chk_idx_reg;
            end
            if (covers && (!hit_reg || ent.len > best_len_reg))
            begin
                hit_next      = 1'b1;
                best_len_next = ent.len;
                best_key_next = ent.tag;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    rd_idx_next     = '0;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    del_found_next  = 1'b0;
                    hit_next        = 1'b0;
                    best_len_next   = '0;
                    best_key_next   = '0;
                    if (head.kind == kind_t'('0))
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                chk_next = 1'b1;
                if (rd_idx_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_LAST:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    state_next         = S_IDLE;
                    rsp_valid_next     = 1'b1;
                    rsp_next           = '0;
                    rsp_next.hit       = cur_reg.kind.lkp & hit_reg;
                    rsp_next.match_key = (cur_reg.kind.lkp && hit_reg) ? best_key_reg : '0;
                    rsp_next.status    = ST_DONE;
                    if (cur_reg.kind.ins)
                    begin
                        if (dup_reg)
                        begin
                            rsp_next.status = ST_DUP;
                        end
                        else if (!free_found_reg)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            valid_next[free_idx_reg] = 1'b1;
                        end
                    end
                    if (cur_reg.kind.del)
                    begin
                        if (del_found_reg)
                        begin
                            valid_next[del_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            rsp_next.status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            chk_reg        <= 1'b0;
            dup_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            del_found_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            chk_reg        <= chk_next;
            dup_reg        <= dup_next;
            free_found_reg <= free_found_next;
            del_found_reg  <= del_found_next;
            hit_reg        <= hit_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        chk_live_reg  <= valid_reg[rd_idx_reg];
        chk_idx_reg   <= rd_idx_reg;
        free_idx_reg  <= free_idx_next;
        del_idx_reg   <= del_idx_next;
        best_len_reg  <= best_len_next;
        best_key_reg  <= best_key_next;
        rsp_reg       <= rsp_next;
    end

endmodule

// ===== sv/ipv4_prefix_match_table.sv =====
// Top level of the IPv4 prefix match table.
// Holds up to TABLE_ENTRIES IPv4 prefixes with a 7-bit route key each. Every insert,
// delete and lookup scans the whole entry memory through its single read port, one
// entry per cycle; an unused operation code skips the scan. A two-entry queue behind
// the request port keeps accepting requests while a scan runs until it is full, and
// the result register frees the engine as soon as a result is latched. Inserts fill
// the lowest free entry; the table comes out of reset empty with no clearing pass.
`include "ipv4_prefix_match_table_assert.svh"

module ipv4_prefix_match_table #(
    parameter int TABLE_ENTRIES = ipm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ipm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ipm_pkg::rsp_t rsp
);
    import ipm_pkg::*;

    q_item_t f_item;
    q_item_t q_head;
    logic    f_push;
    logic    q_full;
    logic    q_head_valid;
    logic    q_pop;
    logic    eng_busy;

    ipm_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .push      (f_push),
        .item      (f_item)
    );

    ipm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_item  (f_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ipm_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .busy       (eng_busy),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

    `IPM_ASSERT_SAME(a_pop_nonempty, clk, rst_n, q_pop, q_head_valid)
    `IPM_ASSERT_NEXT(a_pop_starts_work, clk, rst_n, q_pop, eng_busy)
    `IPM_ASSERT_SAME(a_hit_is_done, clk, rst_n, rsp_valid && rsp.hit, rsp.status == ST_DONE)
    `IPM_ASSERT_SAME(a_miss_key_zero, clk, rst_n, rsp_valid && !rsp.hit, rsp.match_key == '0)

endmodule
